[design/dwb_pkg.sv]
`default_nettype none
package dwb_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int WINDOW_RANGE = 1;

    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int EXT_W       = (ADDR_W + 1 > 23) ? ADDR_W + 1 : 23;

    localparam int OFS_W   = $clog2(WINDOW_RANGE) + 2;
    localparam int PIX_MAX = (2 * WINDOW_RANGE - 1) * (2 * WINDOW_RANGE - 1);
    localparam int CNT_W   = $clog2(PIX_MAX + 1);

    localparam int PROD_W  = 33;
    localparam int SUM_W   = PROD_W + CNT_W;
    localparam int SZ_W    = 16 + CNT_W;
    localparam int NUM_W   = 34 + CNT_W;
    localparam int DEN_W   = 17 + CNT_W;
    localparam int COL_W   = 27;
    localparam int COORD_W = COL_W + 2;
    localparam int CYC_W   = $clog2(NUM_W + 1);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 96;
    localparam int PADDR_W    = 5;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_RGB_WIDTH,
        REG_RGB_HEIGHT,
        REG_DEPTH_WIDTH,
        REG_DEPTH_HEIGHT,
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_PRINCIPAL_X,
        REG_PRINCIPAL_Y
    } reg_idx_t;

    typedef enum logic [2:0] {
        DIV_COL,
        DIV_ROW,
        DIV_X,
        DIV_Y,
        DIV_Z
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_ROW_GO,
        ST_ROW_WAIT,
        ST_PIX_POS,
        ST_PIX_ADDR,
        ST_PIX_READ,
        ST_PIX_MUL,
        ST_PIX_ACC,
        ST_CHECK,
        ST_SUM_GO,
        ST_SUM_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [12:0] rgb_width;
        logic [12:0] rgb_height;
        logic [10:0] depth_width;
        logic [10:0] depth_height;
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [15:0] principal_x;
        logic [15:0] principal_y;
    } cfg_t;

    typedef struct packed {
        logic     load;
        logic     capture;
        logic     pos;
        logic     addr;
        logic     read;
        logic     mul;
        logic     acc;
        logic     div_start;
        logic     latch;
        div_sel_t div_sel;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic last_pix;
        logic n_zero;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

[design/dwb_divider.sv]
`default_nettype none
module dwb_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [dwb_pkg::NUM_W-1:0]  num,
    input  wire logic [dwb_pkg::DEN_W-1:0]  den,
    output logic                            busy,
    output logic                            done,
    output logic [dwb_pkg::NUM_W-1:0]       quot
);
    import dwb_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CYC_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] numr_reg, numr_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        shifted   = {rem_reg, numr_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        numr_next = numr_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CYC_W'(NUM_W);
            numr_next = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            numr_next = {numr_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next  = cnt_reg - CYC_W'(1);
            if (cnt_reg == CYC_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        numr_reg <= numr_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = numr_reg;

endmodule
`default_nettype wire

[design/dwb_datapath.sv]
`default_nettype none
module dwb_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire dwb_pkg::cfg_t                   cfg,
    input  wire dwb_pkg::cmd_t                   cmd,
    input  wire logic [dwb_pkg::IN_DATA_W-1:0]   s_tdata,
    output dwb_pkg::stat_t                       stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dwb_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import dwb_pkg::*;

    logic [15:0] mem [STORE_WORDS];

    logic [19:0] in_index;
    logic [15:0] in_depth;
    logic [15:0] in_bx, in_by;
    logic [7:0]  in_tag;

    logic [15:0] bx_reg, by_reg;
    logic [7:0]  tag_reg;
    logic [COL_W-1:0] col_reg, row_reg;
    logic signed [OFS_W-1:0]   dx_reg, dy_reg;
    logic signed [COORD_W-1:0] u_reg, v_reg;
    logic              frame_ok_reg, pix_ok_reg, acc_ok_reg;
    logic [EXT_W-1:0]  addr_reg;
    logic [15:0]       rd_reg, d_reg;
    logic signed [PROD_W-1:0] px_prod_reg, py_prod_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic [SZ_W-1:0]   sz_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [31:0]       x_res_reg, y_res_reg;
    logic [15:0]       z_res_reg;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [EXT_W-1:0]  load_addr;
    logic [COL_W-1:0]  col_num, row_num;
    logic [12:0]       rw_eff, rh_eff;
    logic [15:0]       fx_eff, fy_eff;
    logic [15+CNT_W:0] fxn, fyn;
    logic [SUM_W-1:0]  mag_x, mag_y;
    logic [NUM_W-1:0]  div_num, quot;
    logic [DEN_W-1:0]  div_den;
    logic              div_busy, div_done;
    logic signed [16:0] diff_x, diff_y;
    logic [22:0]       raster;
    logic signed [OFS_W-1:0] ofs_hi, ofs_lo;

    assign in_index = s_tdata[19:0];
    assign in_depth = s_tdata[35:20];
    assign in_bx    = s_tdata[51:36];
    assign in_by    = s_tdata[67:52];
    assign in_tag   = s_tdata[75:68];

    assign ofs_hi = OFS_W'(WINDOW_RANGE - 1);
    assign ofs_lo = -ofs_hi;

    assign load_addr = EXT_W'(in_index);

    always_ff @(posedge aclk) begin
        if (cmd.load && load_addr < EXT_W'(STORE_WORDS)) begin
            mem[load_addr[ADDR_W-1:0]] <= in_depth;
        end
        if (cmd.read) begin
            rd_reg <= mem[addr_reg[ADDR_W-1:0]];
        end
    end

    // divider operands
    always_comb begin
        rw_eff  = (cfg.rgb_width == '0) ? 13'd1 : cfg.rgb_width;
        rh_eff  = (cfg.rgb_height == '0) ? 13'd1 : cfg.rgb_height;
        fx_eff  = (cfg.focal_x == '0) ? 16'd1 : cfg.focal_x;
        fy_eff  = (cfg.focal_y == '0) ? 16'd1 : cfg.focal_y;
        col_num = bx_reg * cfg.depth_width;
        row_num = by_reg * cfg.depth_height;
        fxn     = fx_eff * n_reg;
        fyn     = fy_eff * n_reg;
        mag_x   = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
        mag_y   = sy_reg[SUM_W-1] ? SUM_W'(-sy_reg) : SUM_W'(sy_reg);
        unique case (cmd.div_sel)
            DIV_COL: begin
                div_num = NUM_W'(col_num);
                div_den = DEN_W'({rw_eff, 4'b0});
            end
            DIV_ROW: begin
                div_num = NUM_W'(row_num);
                div_den = DEN_W'({rh_eff, 4'b0});
            end
            DIV_X: begin
                div_num = NUM_W'({mag_x, 1'b0}) + NUM_W'(fxn);
                div_den = {fxn, 1'b0};
            end
            DIV_Y: begin
                div_num = NUM_W'({mag_y, 1'b0}) + NUM_W'(fyn);
                div_den = {fyn, 1'b0};
            end
            DIV_Z: begin
                div_num = NUM_W'({sz_reg, 1'b0}) + NUM_W'(n_reg);
                div_den = DEN_W'({n_reg, 1'b0});
            end
            default: begin
                div_num = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    dwb_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (quot)
    );

    function automatic logic [31:0] sat_signed(input logic neg, input logic [NUM_W-1:0] q);
        logic [NUM_W-1:0] nq;
        nq = -q;
        if (!neg) begin
            sat_signed = (q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            sat_signed = (q > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : nq[31:0];
        end
    endfunction

    assign diff_x = $signed({2'b0, u_reg[10:0], 4'b0}) - $signed({1'b0, cfg.principal_x});
    assign diff_y = $signed({2'b0, v_reg[10:0], 4'b0}) - $signed({1'b0, cfg.principal_y});
    assign raster = v_reg[10:0] * cfg.depth_width + 23'(u_reg[10:0]);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            bx_reg  <= in_bx;
            by_reg  <= in_by;
            tag_reg <= in_tag;
        end
        if (cmd.pos) begin
            u_reg <= $signed({2'b0, col_reg}) + COORD_W'(dx_reg);
            v_reg <= $signed({2'b0, row_reg}) + COORD_W'(dy_reg);
        end
        if (cmd.addr) begin
            frame_ok_reg <= !u_reg[COORD_W-1] && !v_reg[COORD_W-1]
                         && (u_reg[COORD_W-2:0] < (COORD_W-1)'(cfg.depth_width))
                         && (v_reg[COORD_W-2:0] < (COORD_W-1)'(cfg.depth_height));
            addr_reg     <= EXT_W'(raster);
        end
        if (cmd.read) begin
            pix_ok_reg <= frame_ok_reg && (addr_reg < EXT_W'(STORE_WORDS));
        end
        if (cmd.mul) begin
            px_prod_reg <= PROD_W'(diff_x) * PROD_W'($signed({1'b0, rd_reg}));
            py_prod_reg <= PROD_W'(diff_y) * PROD_W'($signed({1'b0, rd_reg}));
            d_reg       <= rd_reg;
            acc_ok_reg  <= pix_ok_reg && (rd_reg != '0);
        end
        if (cmd.latch) begin
            unique case (cmd.div_sel)
                DIV_COL: col_reg   <= quot[COL_W-1:0];
                DIV_ROW: row_reg   <= quot[COL_W-1:0];
                DIV_X:   x_res_reg <= sat_signed(sx_reg[SUM_W-1], quot);
                DIV_Y:   y_res_reg <= sat_signed(sy_reg[SUM_W-1], quot);
                DIV_Z:   z_res_reg <= quot[15:0];
                default: z_res_reg <= z_res_reg;
            endcase
        end
        if (cmd.emit) begin
            m_data_reg <= {tag_reg, 8'(n_reg), z_res_reg, y_res_reg, x_res_reg};
        end
    end

    // window walk and sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg <= '0;
            dy_reg <= '0;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            n_reg  <= '0;
        end else if (cmd.capture) begin
            dx_reg <= ofs_lo;
            dy_reg <= ofs_lo;
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            n_reg  <= '0;
        end else if (cmd.acc) begin
            if (dx_reg == ofs_hi) begin
                dx_reg <= ofs_lo;
                dy_reg <= dy_reg + OFS_W'(1);
            end else begin
                dx_reg <= dx_reg + OFS_W'(1);
            end
            if (acc_ok_reg) begin
                sx_reg <= sx_reg + SUM_W'(px_prod_reg);
                sy_reg <= sy_reg + SUM_W'(py_prod_reg);
                sz_reg <= sz_reg + SZ_W'(d_reg);
                n_reg  <= n_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;
    assign stat.last_pix = (dx_reg == ofs_hi) && (dy_reg == ofs_hi);
    assign stat.n_zero   = (n_reg == '0);
    assign stat.out_free = !m_valid_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !m_valid_reg)
        else $error("result written over a pending one");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && acc_ok_reg) |-> (n_reg != CNT_W'(PIX_MAX)))
        else $error("pixel count beyond window size");

endmodule
`default_nettype wire

[design/dwb_ctrl.sv]
`default_nettype none
module dwb_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    input  wire logic           s_tuser,
    input  wire dwb_pkg::stat_t stat,
    output logic                s_tready,
    output dwb_pkg::cmd_t       cmd
);
    import dwb_pkg::*;

    state_t   state_reg, state_next;
    div_sel_t sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= DIV_COL;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (op_t'(s_tuser) == OP_QUERY) begin
                        cmd.capture = 1'b1;
                        sel_next    = DIV_COL;
                        state_next  = ST_COL_GO;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_COL_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_COL_WAIT;
            end
            ST_COL_WAIT: begin
                if (stat.div_done) begin
                    cmd.latch  = 1'b1;
                    sel_next   = DIV_ROW;
                    state_next = ST_ROW_GO;
                end
            end
            ST_ROW_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                if (stat.div_done) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_PIX_POS;
                end
            end
            ST_PIX_POS: begin
                cmd.pos    = 1'b1;
                state_next = ST_PIX_ADDR;
            end
            ST_PIX_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_PIX_READ;
            end
            ST_PIX_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_PIX_MUL;
            end
            ST_PIX_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PIX_ACC;
            end
            ST_PIX_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.last_pix ? ST_CHECK : ST_PIX_POS;
            end
            ST_CHECK: begin
                sel_next   = DIV_X;
                state_next = stat.n_zero ? ST_IDLE : ST_SUM_GO;
            end
            ST_SUM_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_SUM_WAIT;
            end
            ST_SUM_WAIT: begin
                if (stat.div_done) begin
                    cmd.latch = 1'b1;
                    priority case (sel_reg)
                        DIV_X: begin
                            sel_next   = DIV_Y;
                            state_next = ST_SUM_GO;
                        end
                        DIV_Y: begin
                            sel_next   = DIV_Z;
                            state_next = ST_SUM_GO;
                        end
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[design/depth_window_backprojection.sv]
// Depth window back-projection.
// Input stream (s_*): tuser selects the request kind, load or query. A load
// writes one depth pixel into the 1M-word frame memory. A query scales the
// box centre into depth coordinates, walks the window of (2*WINDOW_RANGE-1)^2
// pixels, back-projects each valid pixel and averages X, Y and Z; at most one
// result follows on the output stream (m_*). The five divisions run one after
// another on a single bit-serial divider; each window pixel takes five steps
// through the one memory read port.
// Items are taken one at a time; the next request is accepted as soon as
// the query finishes, even while its result waits in the output register.
// A stalled receiver only holds the output register; a later query then
// waits before writing its result, and loads wait behind that query.
// Reset clears control state and restores the register defaults; the frame
// memory is not cleared and must be loaded before it is read.
// Configuration (APB, registers at byte address 4*index) must be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module depth_window_backprojection (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pixel_index[19:0], depth_mm[35:20], box_center_x[51:36],
    // box_center_y[67:52], class_tag[75:68]
    input  wire logic [dwb_pkg::IN_DATA_W-1:0]  s_tdata,
    // op
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // point_x_mm[31:0], point_y_mm[63:32], point_z_mm[79:64],
    // valid_count[87:80], result_tag[95:88]
    output logic [dwb_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dwb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import dwb_pkg::*;

    cfg_t     cfg_reg;
    cmd_t     cmd;
    stat_t    stat;
    reg_idx_t reg_idx;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rgb_width    <= 13'd640;
            cfg_reg.rgb_height   <= 13'd480;
            cfg_reg.depth_width  <= 11'd640;
            cfg_reg.depth_height <= 11'd480;
            cfg_reg.focal_x      <= 16'd8000;
            cfg_reg.focal_y      <= 16'd8000;
            cfg_reg.principal_x  <= 16'd5120;
            cfg_reg.principal_y  <= 16'd3840;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_RGB_WIDTH:    cfg_reg.rgb_width    <= pwdata[12:0];
                REG_RGB_HEIGHT:   cfg_reg.rgb_height   <= pwdata[12:0];
                REG_DEPTH_WIDTH:  cfg_reg.depth_width  <= pwdata[10:0];
                REG_DEPTH_HEIGHT: cfg_reg.depth_height <= pwdata[10:0];
                REG_FOCAL_X:      cfg_reg.focal_x      <= pwdata[15:0];
                REG_FOCAL_Y:      cfg_reg.focal_y      <= pwdata[15:0];
                REG_PRINCIPAL_X:  cfg_reg.principal_x  <= pwdata[15:0];
                REG_PRINCIPAL_Y:  cfg_reg.principal_y  <= pwdata[15:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RGB_WIDTH:    prdata = 32'(cfg_reg.rgb_width);
            REG_RGB_HEIGHT:   prdata = 32'(cfg_reg.rgb_height);
            REG_DEPTH_WIDTH:  prdata = 32'(cfg_reg.depth_width);
            REG_DEPTH_HEIGHT: prdata = 32'(cfg_reg.depth_height);
            REG_FOCAL_X:      prdata = 32'(cfg_reg.focal_x);
            REG_FOCAL_Y:      prdata = 32'(cfg_reg.focal_y);
            REG_PRINCIPAL_X:  prdata = 32'(cfg_reg.principal_x);
            REG_PRINCIPAL_Y:  prdata = 32'(cfg_reg.principal_y);
            default:          prdata = '0;
        endcase
    end

    dwb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    dwb_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
